/* rtl/core/idac_pkg.sv */
// ----------------------------------------------------------------------------
// idac_pkg: shared types and constants of the IR dock alignment controller
// Contact codes, motion codes and the classified item handed front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package idac_pkg;

  localparam int unsigned DebounceFramesDef = 40;
  localparam int unsigned TimeoutFramesDef  = 250;

  localparam logic [7:0] CodeCharge = 8'hAA;
  localparam logic [7:0] CodeSense  = 8'hBB;
  localparam logic [7:0] CodeBoth   = 8'hCF;
  localparam logic [7:0] CodeLatch  = 8'hFC;
  localparam logic [7:0] CodeFull   = 8'hAB;

  localparam logic [3:0] MvStop  = 4'd0;
  localparam logic [3:0] MvFront = 4'd1;
  localparam logic [3:0] MvBack  = 4'd2;
  localparam logic [3:0] MvFl    = 4'd3;
  localparam logic [3:0] MvFr    = 4'd4;
  localparam logic [3:0] MvBl    = 4'd5;
  localparam logic [3:0] MvBr    = 4'd6;
  localparam logic [3:0] MvAdjL  = 4'd7;
  localparam logic [3:0] MvAdjR  = 4'd8;

  localparam logic [6:0] LeaveStd  = 7'd75;
  localparam logic [6:0] LeaveShort = 7'd80;
  localparam logic [6:0] LeaveLong = 7'd113;

  typedef struct packed {
    logic [7:0]         touch;
    logic [3:0]         pat;
    logic               enable;
    logic               full;
    logic [2:0]         count;
    logic signed [12:0] cur_ma;
  } front_item_t;

endpackage
`default_nettype wire

/* rtl/core/ir_dock_alignment_controller.sv */
// ----------------------------------------------------------------------------
// ir_dock_alignment_controller: charger docking steering from status frames
// Usage:
//   Slave stream carries one charger status frame per item; master stream
//   returns one result item per frame, in order.
//   vehicle_type is written via cfg_we_i/cfg_wdata_i while idle.
//   An accepted item passes the front decode register, then the back state
//   update and result register; back state updates run back to back.
//   Throughput: one item per cycle while the master side takes results.
//   Reset clears all docking state and vehicle_type; no items are held.
//   A stalled master side holds the result; the front register takes one
//   more item, then s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module ir_dock_alignment_controller #(
  parameter int unsigned DebounceFrames = idac_pkg::DebounceFramesDef,
  parameter int unsigned TimeoutFrames  = idac_pkg::TimeoutFramesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // contact_code[7:0], ir_flags[15:8], current_raw[23:16],
  // recharge_enabled[24], battery_full[25], zero fill
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // motion[3:0], charging[4], ir_count[7:5], charge_current_ma[20:8],
  // clear_enable[21], zero fill
  output logic [23:0]      m_axis_tdata
);
  import idac_pkg::*;

  logic [2:0]  vtype_q;
  logic        qv, qr;
  front_item_t qi;
  logic [3:0]  mot;
  logic        chg, clr;
  logic [2:0]  cnt;
  logic signed [12:0] cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vtype_q <= 3'd0;
    else if (cfg_we_i) vtype_q <= cfg_wdata_i;
  end

  idac_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .contact_i(s_axis_tdata[7:0]), .flags_i(s_axis_tdata[15:8]),
    .raw_i(s_axis_tdata[23:16]), .enable_i(s_axis_tdata[24]),
    .full_i(s_axis_tdata[25]),
    .q_valid_o(qv), .q_ready_i(qr), .q_item_o(qi)
  );

  idac_back #(.DebounceFrames(DebounceFrames), .TimeoutFrames(TimeoutFrames)) u_back (
    .clk_i, .rst_ni, .vehicle_type_i(vtype_q),
    .q_valid_i(qv), .q_ready_o(qr), .q_item_i(qi),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .motion_o(mot), .charging_o(chg), .ir_count_o(cnt), .current_o(cur),
    .clear_o(clr)
  );

  assign m_axis_tdata = {2'd0, clr, cur, cnt, chg, mot};
endmodule
`default_nettype wire

/* rtl/core/idac_front.sv */
// ----------------------------------------------------------------------------
// idac_front: input stage
// Accepts frame items, decodes beam pattern, beam count and current in mA.
// ----------------------------------------------------------------------------
`default_nettype none
module idac_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           contact_i,
  input  wire logic [7:0]           flags_i,
  input  wire logic [7:0]           raw_i,
  input  wire logic                 enable_i,
  input  wire logic                 full_i,
  output logic                      q_valid_o,
  input  wire logic                 q_ready_i,
  output idac_pkg::front_item_t     q_item_o
);
  import idac_pkg::*;

  front_item_t item_d, item_q;
  logic        valid_q;
  logic [3:0]  pat;
  logic [8:0]  mag;
  logic [13:0] prod;

  assign in_ready_o = !valid_q || q_ready_i;
  assign pat = flags_i[5:2];
  assign mag = (raw_i > 8'd128) ? (9'd256 - {1'b0, raw_i}) : {1'b0, raw_i};
  assign prod = {mag, 5'd0} - {4'd0, mag, 1'b0};

  always_comb begin
    item_d.touch  = contact_i;
    item_d.pat    = pat;
    item_d.enable = enable_i;
    item_d.full   = full_i;
    item_d.count  = 3'({2'd0, pat[0]} + {2'd0, pat[1]} + {2'd0, pat[2]} + {2'd0, pat[3]});
    if (pat == 4'd0 || pat == 4'd5) item_d.count = 3'd0;
    item_d.cur_ma = (raw_i > 8'd128) ? -$signed(prod[12:0]) : $signed(prod[12:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) item_q <= item_d;
  end

  assign q_valid_o = valid_q;
  assign q_item_o  = item_q;
endmodule
`default_nettype wire

/* rtl/core/idac_back.sv */
// ----------------------------------------------------------------------------
// idac_back: docking state machine and result register
// Updates contact, leave and timeout state once per item; registers result.
// ----------------------------------------------------------------------------
`default_nettype none
module idac_back #(
  parameter int unsigned DebounceFrames = idac_pkg::DebounceFramesDef,
  parameter int unsigned TimeoutFrames  = idac_pkg::TimeoutFramesDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [2:0]           vehicle_type_i,
  input  wire logic                 q_valid_i,
  output logic                      q_ready_o,
  input  wire idac_pkg::front_item_t q_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [3:0]                motion_o,
  output logic                      charging_o,
  output logic [2:0]                ir_count_o,
  output logic signed [12:0]        current_o,
  output logic                      clear_o
);
  import idac_pkg::*;

  localparam logic [5:0] DebLim = 6'(DebounceFrames);
  localparam logic [7:0] ToLim  = 8'(TimeoutFrames);

  logic [3:0] pnow_q, pnow_d, pbef_q, pbef_d;
  logic [7:0] cbef_q, cbef_d;
  logic [1:0] lock_q, lock_d, lmode_q, lmode_d;
  logic [6:0] ltim_q, ltim_d;
  logic [5:0] cdeb_q, cdeb_d, sdeb_q, sdeb_d;
  logic [7:0] adj_q, adj_d, ctc_q, ctc_d, sto_q, sto_d, dto_q, dto_d;
  logic [7:0] shd_q, shd_d, lcnt_q, lcnt_d;
  logic       cseen_q, cseen_d, sseen_q, sseen_d, latch_q, latch_d;
  logic       ovalid_q;
  logic [3:0] mot_d;
  logic       clr_d;
  logic       fire;

  function automatic logic [7:0] inc8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [3:0] beam(input logic [3:0] p, input logic [3:0] b);
    case (p)
      4'd1:  beam = MvFr;
      4'd2:  beam = MvBl;
      4'd3:  beam = MvFr;
      4'd4:  beam = MvFl;
      4'd6:  beam = (b == 4'd2) ? MvBack : MvFl;
      4'd7:  beam = MvBack;
      4'd8:  beam = (b == 4'd9) ? MvBack : MvBr;
      4'd9:  beam = (b == 4'd8 || b == 4'd1) ? MvBack : MvFr;
      4'd10: beam = MvBack;
      4'd11: beam = (b == 4'd9) ? MvBack : MvFr;
      4'd12: beam = MvBr;
      4'd13: beam = MvBack;
      4'd14: beam = (b == 4'd6 || b == 4'd3) ? MvBack : MvFl;
      4'd15: beam = MvBack;
      default: beam = MvStop;
    endcase
  endfunction

  assign q_ready_o = !ovalid_q || out_ready_i;
  assign fire = q_valid_i && q_ready_o;

  always_comb begin
    logic [7:0] touch;
    logic       en;
    logic [6:0] leave;
    logic [6:0] lt;
    logic [5:0] f;
    touch = q_item_i.touch;
    en = q_item_i.enable;
    leave = LeaveStd;
    lt = 7'd0;
    f = 6'd0;
    clr_d = 1'b0;
    pnow_d = pnow_q; pbef_d = pbef_q; lock_d = lock_q; lmode_d = lmode_q;
    ltim_d = ltim_q; cdeb_d = cdeb_q; sdeb_d = sdeb_q; adj_d = adj_q;
    ctc_d = ctc_q; sto_d = sto_q; dto_d = dto_q; shd_d = shd_q; lcnt_d = lcnt_q;
    cseen_d = cseen_q; sseen_d = sseen_q; latch_d = latch_q;
    if (sseen_d && cseen_d) begin
      sseen_d = 1'b0; cseen_d = 1'b0; adj_d = inc8(adj_d);
    end
    if (cbef_q != CodeCharge && touch == CodeCharge) begin
      sto_d = 8'd0; ctc_d = inc8(ctc_d); dto_d = 8'd0;
    end
    if (cbef_q != CodeSense && touch == CodeSense) dto_d = 8'd0;
    cbef_d = touch;
    if (adj_d != 8'd0) dto_d = inc8(dto_d);
    if (dto_d > ToLim) begin adj_d = 8'd0; dto_d = 8'd0; end
    if (ctc_d != 8'd0) sto_d = inc8(sto_d);
    if (sto_d > ToLim) begin ctc_d = 8'd0; sto_d = 8'd0; end
    if (latch_d && touch != CodeCharge && touch != CodeBoth) begin
      if (touch == CodeFull && q_item_i.full) begin en = 1'b0; clr_d = 1'b1; end
      adj_d = 8'd0; latch_d = 1'b0;
    end
    if (latch_d) touch = CodeLatch;
    if (!en) begin
      adj_d = 8'd0; latch_d = 1'b0; ctc_d = 8'd0;
    end else if (vehicle_type_i <= 3'd1) begin
      leave = LeaveShort;
    end else if (vehicle_type_i == 3'd4 || vehicle_type_i == 3'd5) begin
      leave = LeaveLong;
    end
    if (en) begin
      if (q_item_i.pat != pnow_d) pbef_d = pnow_d;
      pnow_d = q_item_i.pat;
    end
    mot_d = beam(q_item_i.pat, pbef_d);
    if (touch == CodeCharge || lock_d == 2'd1) begin
      mot_d = MvStop;
      if (cdeb_d >= DebLim) begin
        cseen_d = 1'b1; f = DebLim + 6'd1; lock_d = 2'd1; mot_d = MvAdjR;
        if (adj_d == 8'd2 || (ctc_d >= 8'd3 && adj_d != 8'd0)) begin
          mot_d = MvStop; latch_d = 1'b1; ctc_d = 8'd0;
        end
      end else begin
        f = cdeb_d + 6'd1;
      end
      cdeb_d = f;
    end else if (touch == CodeSense || lock_d == 2'd2) begin
      mot_d = MvStop;
      if (sdeb_d >= DebLim) begin
        sseen_d = 1'b1; f = DebLim + 6'd1; lock_d = 2'd2; mot_d = MvAdjL;
      end else begin
        f = sdeb_d + 6'd1;
      end
      sdeb_d = f;
    end else if (touch == CodeBoth || touch == CodeLatch) begin
      latch_d = 1'b1; ctc_d = 8'd0; mot_d = MvStop;
    end
    if (lock_d != 2'd0) begin
      lt = ltim_d + 7'd1;
      ltim_d = lt;
      if (lt > leave) begin
        if (lock_d == 2'd1 || lock_d == 2'd2) lmode_d = lock_d;
        lock_d = 2'd0; ltim_d = 7'd0; cdeb_d = 6'd0; sdeb_d = 6'd0;
      end
    end else begin
      ltim_d = 7'd0;
    end
    if (lmode_d != 2'd0) begin
      lcnt_d = inc8(lcnt_d);
      if (lcnt_d == 8'hFF) begin lcnt_d = 8'd0; lmode_d = 2'd0; shd_d = 8'd0; end
      if (q_item_i.pat == 4'd9) begin mot_d = MvFr; shd_d = inc8(shd_d); end
      else if (q_item_i.pat == 4'd6) begin mot_d = MvFl; shd_d = inc8(shd_d); end
      else if (q_item_i.pat != 4'd15) begin mot_d = MvFront; shd_d = 8'd0; end
      if (shd_d > ToLim) begin adj_d = 8'd0; ctc_d = 8'd0; end
      if (pbef_d == 4'd15 || pbef_d == 4'd9 || pbef_d == 4'd6) begin
        lcnt_d = 8'd0; lmode_d = 2'd0; shd_d = 8'd0;
      end
    end
    if (latch_d) mot_d = MvStop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pnow_q <= '0; pbef_q <= '0; cbef_q <= '0; lock_q <= '0; lmode_q <= '0;
      ltim_q <= '0; cdeb_q <= '0; sdeb_q <= '0; adj_q <= '0; ctc_q <= '0;
      sto_q <= '0; dto_q <= '0; shd_q <= '0; lcnt_q <= '0;
      cseen_q <= 1'b0; sseen_q <= 1'b0; latch_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      if (q_ready_o) ovalid_q <= q_valid_i;
      if (fire) begin
        pnow_q <= pnow_d; pbef_q <= pbef_d; cbef_q <= cbef_d; lock_q <= lock_d;
        lmode_q <= lmode_d; ltim_q <= ltim_d; cdeb_q <= cdeb_d; sdeb_q <= sdeb_d;
        adj_q <= adj_d; ctc_q <= ctc_d; sto_q <= sto_d; dto_q <= dto_d;
        shd_q <= shd_d; lcnt_q <= lcnt_d; cseen_q <= cseen_d; sseen_q <= sseen_d;
        latch_q <= latch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      motion_o   <= mot_d;
      charging_o <= latch_d;
      ir_count_o <= q_item_i.count;
      current_o  <= q_item_i.cur_ma;
      clear_o    <= clr_d;
    end
  end

  assign out_valid_o = ovalid_q;
endmodule
`default_nettype wire

/* dv/idac_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idac_checker: result predictor and comparator for the dock controller
// Watches the config port and both streams, predicts each result item from
// its own copy of the docking state and compares the whole item.
// ----------------------------------------------------------------------------
module idac_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          errors_o,
  output int          pending_o
);
  import idac_pkg::*;

  localparam int unsigned Debounce = DebounceFramesDef;
  localparam int unsigned Timeout  = TimeoutFramesDef;

  logic [23:0] exp_q[$];

  logic [2:0] veh;
  logic [3:0] pat_now, pat_before;
  logic [7:0] contact_before;
  logic [1:0] lock, leave_mode;
  logic [6:0] leave_timer;
  logic [5:0] chg_deb, sns_deb;
  logic [7:0] adj_cnt, chg_cnt, single_to, double_to, shield_cnt, leave_cnt;
  logic       chg_seen, sns_seen, latch;

  assign pending_o = exp_q.size();

  function automatic logic [7:0] sat_inc(logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [3:0] steer(logic [3:0] p, logic [3:0] b);
    case (p)
      4'd1, 4'd3: return MvFr;
      4'd2:       return MvBl;
      4'd4:       return MvFl;
      4'd6:       return (b == 4'd2) ? MvBack : MvFl;
      4'd7, 4'd10, 4'd13, 4'd15: return MvBack;
      4'd8:       return (b == 4'd9) ? MvBack : MvBr;
      4'd9:       return (b == 4'd8 || b == 4'd1) ? MvBack : MvFr;
      4'd11:      return (b == 4'd9) ? MvBack : MvFr;
      4'd12:      return MvBr;
      4'd14:      return (b == 4'd6 || b == 4'd3) ? MvBack : MvFl;
      default:    return MvStop;
    endcase
  endfunction

  task automatic dock_step(input logic [31:0] d);
    logic [7:0] touch, raw;
    logic [3:0] p, mv;
    logic [2:0] cnt;
    logic       en, full, clr, aa_edge, bb_edge;
    logic [6:0] leave;
    int         f, cur;
    logic signed [12:0] cur_ma;
    touch = d[7:0];
    p     = d[13:10];
    raw   = d[23:16];
    en    = d[24];
    full  = d[25];
    clr   = 1'b0;
    leave = LeaveStd;
    if (sns_seen && chg_seen) begin
      sns_seen = 0;
      chg_seen = 0;
      adj_cnt  = sat_inc(adj_cnt);
    end
    aa_edge = contact_before != CodeCharge && touch == CodeCharge;
    bb_edge = contact_before != CodeSense && touch == CodeSense;
    if (aa_edge) begin
      single_to = 0;
      chg_cnt   = sat_inc(chg_cnt);
    end
    if (aa_edge || bb_edge) double_to = 0;
    contact_before = touch;
    if (adj_cnt > 0) double_to = sat_inc(double_to);
    if (double_to > Timeout) begin
      adj_cnt   = 0;
      double_to = 0;
    end
    if (chg_cnt > 0) single_to = sat_inc(single_to);
    if (single_to > Timeout) begin
      chg_cnt   = 0;
      single_to = 0;
    end
    if (latch && touch != CodeCharge && touch != CodeBoth) begin
      if (touch == CodeFull && full) begin
        en  = 0;
        clr = 1;
      end
      adj_cnt = 0;
      latch   = 0;
    end
    if (latch) touch = CodeLatch;
    if (!en) begin
      adj_cnt = 0;
      latch   = 0;
      chg_cnt = 0;
    end else if (veh <= 3'd1) begin
      leave = LeaveShort;
    end else if (veh == 3'd4 || veh == 3'd5) begin
      leave = LeaveLong;
    end
    if (en) begin
      if (p != pat_now) pat_before = pat_now;
      pat_now = p;
    end
    cnt = p[0] + p[1] + p[2] + p[3];
    if (p == 4'd0 || p == 4'd5) cnt = 0;
    mv = steer(p, pat_before);
    if (touch == CodeCharge || lock == 2'd1) begin
      f  = chg_deb + 1;
      mv = MvStop;
      if (f > Debounce) begin
        chg_seen = 1;
        f        = Debounce + 1;
        lock     = 2'd1;
        mv       = MvAdjR;
        if (adj_cnt == 2 || (chg_cnt >= 3 && adj_cnt > 0)) begin
          mv      = MvStop;
          latch   = 1;
          chg_cnt = 0;
        end
      end
      chg_deb = f[5:0];
    end else if (touch == CodeSense || lock == 2'd2) begin
      f  = sns_deb + 1;
      mv = MvStop;
      if (f > Debounce) begin
        sns_seen = 1;
        f        = Debounce + 1;
        lock     = 2'd2;
        mv       = MvAdjL;
      end
      sns_deb = f[5:0];
    end else if (touch == CodeBoth || touch == CodeLatch) begin
      latch   = 1;
      chg_cnt = 0;
      mv      = MvStop;
    end
    if (lock != 0) begin
      leave_timer = leave_timer + 1;
      if (leave_timer > leave) begin
        if (lock == 2'd1 || lock == 2'd2) leave_mode = lock;
        lock        = 0;
        leave_timer = 0;
        chg_deb     = 0;
        sns_deb     = 0;
      end
    end else begin
      leave_timer = 0;
    end
    if (leave_mode != 0) begin
      leave_cnt = sat_inc(leave_cnt);
      if (leave_cnt == 8'hFF) begin
        leave_cnt  = 0;
        leave_mode = 0;
        shield_cnt = 0;
      end
      if (p == 4'd9) begin
        mv = MvFr;
        shield_cnt = sat_inc(shield_cnt);
      end else if (p == 4'd6) begin
        mv = MvFl;
        shield_cnt = sat_inc(shield_cnt);
      end else if (p != 4'd15) begin
        mv = MvFront;
        shield_cnt = 0;
      end
      if (shield_cnt > Timeout) begin
        adj_cnt = 0;
        chg_cnt = 0;
      end
      if (pat_before == 4'd15 || pat_before == 4'd9 || pat_before == 4'd6) begin
        leave_cnt  = 0;
        leave_mode = 0;
        shield_cnt = 0;
      end
    end
    if (latch) mv = MvStop;
    cur    = (raw > 8'd128) ? -((256 - raw) * 30) : raw * 30;
    cur_ma = cur;
    exp_q.push_back({2'b0, clr, cur_ma, cnt, latch, mv});
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [23:0] want;
    if (!rst_ni) begin
      veh = 0; pat_now = 0; pat_before = 0; contact_before = 0;
      lock = 0; leave_mode = 0; leave_timer = 0; chg_deb = 0; sns_deb = 0;
      adj_cnt = 0; chg_cnt = 0; single_to = 0; double_to = 0;
      shield_cnt = 0; leave_cnt = 0; chg_seen = 0; sns_seen = 0; latch = 0;
      exp_q.delete();
      errors_o <= 0;
    end else begin
      if (cfg_we_i) veh = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) dock_step(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_q.size() == 0) begin
          errors_o <= errors_o + 1;
          if (errors_o < 10) $display("unexpected result item %h", m_axis_tdata);
        end else begin
          want = exp_q.pop_front();
          if (m_axis_tdata !== want) begin
            errors_o <= errors_o + 1;
            if (errors_o < 10)
              $display("mismatch: mv %0d/%0d chg %b/%b cnt %0d/%0d ma %0d/%0d clr %b/%b",
                       want[3:0], m_axis_tdata[3:0], want[4], m_axis_tdata[4],
                       want[7:5], m_axis_tdata[7:5], $signed(want[20:8]),
                       $signed(m_axis_tdata[20:8]), want[21], m_axis_tdata[21]);
          end
        end
      end
    end
  end
endmodule

/* dv/tb_ir_dock_alignment_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_dock_alignment_controller: stream test of the dock controller
// Directed frames, then docking scenarios with random content under bursty
// input and stalling output, across all chassis types.
// ----------------------------------------------------------------------------
module tb_ir_dock_alignment_controller;
  import idac_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_wdata_i = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  int          errors, pending, cycles;
  int          hold_off = 0;
  bit          hold_req = 0;

  initial forever #6 clk_i = ~clk_i;

  ir_dock_alignment_controller i_dut (.*);

  idac_checker i_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .s_axis_tvalid, .s_axis_tready,
    .s_axis_tdata, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  // receiver: own stall pattern, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_off <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (cycles % 700 < 200) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_frame(input logic [7:0] touch, input logic [7:0] flags,
                            input logic [7:0] raw, input logic en, input logic full);
    s_axis_tdata  <= {6'b0, full, en, raw, flags, touch};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_type(input logic [2:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_touch();
    case ($urandom_range(0, 9))
      0, 1, 2: return CodeCharge;
      3, 4:    return CodeSense;
      5:       return CodeBoth;
      6:       return CodeFull;
      7:       return CodeLatch;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [7:0] pick_flags();
    logic [3:0] p;
    p = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
        : (($urandom_range(0, 1) == 0) ? 4'd15 : (($urandom_range(0, 1) == 0) ? 4'd9 : 4'd6));
    return {2'($urandom_range(0, 3)), p, 2'($urandom_range(0, 3))};
  endfunction

  initial begin
    logic [7:0] touch;
    int         len;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_type(3'd0);
    // directed: all beam patterns, current extremes, contact codes
    for (int p = 0; p < 16; p++) send_frame(8'h00, 8'(p << 2), 8'(p * 17), 1'b1, 1'b0);
    send_frame(8'h00, 8'hFF, 8'd128, 1'b1, 1'b0);
    send_frame(8'h00, 8'h00, 8'd129, 1'b0, 1'b1);
    send_frame(8'h00, 8'hC3, 8'd255, 1'b1, 1'b0);
    send_frame(CodeBoth, 8'h3C, 8'd0, 1'b1, 1'b0);
    send_frame(CodeFull, 8'h3C, 8'd1, 1'b0, 1'b1);
    send_frame(CodeSense, 8'h24, 8'd127, 1'b1, 1'b1);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      set_type(3'(ph));
      for (int s = 0; s < 5; s++) begin
        // contact dwell, mostly long, with occasional noise
        touch = pick_touch();
        len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(20, 60);
        for (int k = 0; k < len; k++)
          send_frame(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : touch,
                     pick_flags(), $urandom_range(0, 255),
                     ($urandom_range(0, 19) != 0), ($urandom_range(0, 3) == 0));
      end
      if (ph == 2) begin
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
        for (int k = 0; k < 20; k++)
          send_frame(CodeCharge, pick_flags(), $urandom_range(0, 255), 1'b1, 1'b0);
      end
      drain();
    end
    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
